// ----- design/pfdl_pkg.sv -----
// shared types and constants of the pps frequency discipline loop
`timescale 1ns / 1ps
package pfdl_pkg;

  // field and register widths
  localparam int unsigned SnapW    = 32;
  localparam int unsigned NomW     = 27;
  localparam int unsigned LimW     = 20;
  localparam int unsigned HitW     = 8;
  localparam int unsigned WinW     = 10;
  localparam int unsigned RunW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 27;

  // serial multiplier shape: signed multiplicand, unsigned multiplier
  localparam int unsigned MulAW    = 32;
  localparam int unsigned MulBW    = 16;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned MulCntW  = 5;

  // window bounds
  localparam logic [WinW-1:0] WinCap      = 10'd512;
  localparam logic [WinW-1:0] StartSecond = 10'd1;

  // register reset values
  localparam logic [NomW-1:0] NomReset   = 27'd20000000;
  localparam logic [LimW-1:0] FastReset  = 20'd10000;
  localparam logic [HitW-1:0] HitsReset  = 8'd10;
  localparam logic [LimW-1:0] SlowReset  = 20'd100;
  localparam logic [WinW-1:0] MaxWinReset = 10'd512;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NOMINAL_HZ   = 3'd0,
    CFG_FAST_LIMIT   = 3'd1,
    CFG_HITS_TO_LOCK = 3'd2,
    CFG_SLOW_LIMIT   = 3'd3,
    CFG_MAX_WINDOW   = 3'd4
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_TGT_WAIT,
    ST_DEV,
    ST_RUN_WAIT,
    ST_OUT
  } state_e;

  // request to the serial multiplier
  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] mcand;
    logic [MulBW-1:0] mplier;
  } mul_req_t;

endpackage

// ----- design/pfdl_in_if.sv -----
// input channel: one pps beat carrying the counter snapshot
`timescale 1ns / 1ps
interface pfdl_in_if;
  import pfdl_pkg::*;

  logic             valid;
  logic             ready;
  logic [SnapW-1:0] count_snapshot;

  modport source (output valid, output count_snapshot, input ready);
  modport sink   (input valid, input count_snapshot, output ready);
endinterface

// ----- design/pfdl_out_if.sv -----
// output channel: one result beat per pps event
`timescale 1ns / 1ps
interface pfdl_out_if;
  import pfdl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    window_done;
  logic signed [31:0]      deviation;
  logic signed [31:0]      correction_total;
  logic                    fast_mode;
  logic [WinW-1:0]         window_seconds;
  logic                    locked;

  modport source (output valid, output window_done, output deviation,
                  output correction_total, output fast_mode,
                  output window_seconds, output locked, input ready);
  modport sink   (input valid, input window_done, input deviation,
                  input correction_total, input fast_mode,
                  input window_seconds, input locked, output ready);
endinterface

// ----- design/pfdl_ser_mul.sv -----
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module pfdl_ser_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfdl_pkg::mul_req_t         req_i,
  output logic                       done_o,
  output logic [pfdl_pkg::ProdW-1:0] prod_o
);
  import pfdl_pkg::*;

  logic [MulAW-1:0]   mcand_q, mcand_d;
  logic [MulBW-1:0]   mplier_q, mplier_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [ProdW-1:0]   addend;

  // multiplicand sign-extended, gated by the multiplier bit leaving the top
  assign addend = mplier_q[MulBW-1] ? {{MulBW{mcand_q[MulAW-1]}}, mcand_q} : '0;

  // msb-first shift and add
  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    prod_d   = prod_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      prod_d   = '0;
      cnt_d    = MulCntW'(MulBW);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      prod_d   = {prod_q[ProdW-2:0], 1'b0} + addend;
      mplier_d = {mplier_q[MulBW-2:0], 1'b0};
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == MulCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ----- design/pps_frequency_discipline_loop_core.sv -----
// top level of the pps frequency discipline loop
`timescale 1ns / 1ps
// Usage
// in_i carries one beat per pps edge holding the oscillator down-counter
// snapshot; out_o returns exactly one result beat for each input beat, in
// order: window flag, deviation, correction total, mode, next window, lock.
// The configuration port writes register cfg_idx_i with cfg_data_i on any
// clock edge with cfg_we_i high; write it only while no beat is in flight.
// A beat that does not close a window passes from the accumulate step to the
// output register; a beat that closes a window first waits for the target
// nominal_hz * window and, when it forms a correction, for the correction
// run * deviation, each formed in the 16-step bit-serial multiplier, one
// multiplier bit a cycle. One beat is worked at a time; the next is accepted
// the cycle after the result has been moved into the output register.
// Reset clears the loop to fast mode with a one-second window and loads the
// default register values; no clearing pass is needed.
// When the receiver stalls, the finished result holds in the output
// register, and a following beat is still accepted and worked; it waits in
// its last step until the output register is free.
module pps_frequency_discipline_loop_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfdl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfdl_pkg::CfgDataW-1:0] cfg_data_i,
  pfdl_in_if.sink                       in_i,
  pfdl_out_if.source                    out_o
);
  import pfdl_pkg::*;

  localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [31:0] SatMin = 32'h8000_0000;
  localparam logic [WinW-1:0] LockWin = 10'd16;

  // configuration registers
  logic [NomW-1:0] nom_q;
  logic [LimW-1:0] fast_lim_q;
  logic [HitW-1:0] hits_q;
  logic [LimW-1:0] slow_lim_q;
  logic [WinW-1:0] max_win_q;

  // loop state
  state_e          state_q, state_d;
  logic [31:0]     prev_q, prev_d;
  logic [WinW-1:0] sic_q, sic_d;
  logic [31:0]     acc_q, acc_d;
  logic [WinW-1:0] wl_q, wl_d;
  logic            fast_q, fast_d;
  logic [RunW-1:0] neg_q, neg_d;
  logic [RunW-1:0] pos_q, pos_d;
  logic [HitW-1:0] zh_q, zh_d;
  logic [31:0]     corr_q, corr_d;
  logic            out_valid_q;

  // per-beat payload
  logic [31:0]     snap_q;
  logic [31:0]     dev_q, dev_d;
  logic            closed_q, closed_d;

  // output register
  logic            res_done_q;
  logic [31:0]     res_dev_q;
  logic [31:0]     res_corr_q;
  logic            res_fast_q;
  logic [WinW-1:0] res_wl_q;
  logic            res_lock_q;

  // helpers
  logic            in_ready;
  logic            load_out;
  mul_req_t        mul_req;
  logic            mul_done;
  logic [ProdW-1:0] mul_prod;
  logic [31:0]     delta;
  logic            close_win;
  logic            dev_neg;
  logic            dev_zero;
  logic [31:0]     mag;
  logic [RunW-1:0] neg_inc;
  logic [RunW-1:0] pos_inc;
  logic [HitW-1:0] zh_inc;
  logic [HitW-1:0] need;
  logic [WinW-1:0] cap;
  logic [WinW:0]   wl_dbl;
  logic [WinW-1:0] wl_half;
  logic [ProdW:0]  sum_w;
  logic            sum_fits;

  pfdl_ser_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q      <= NomReset;
      fast_lim_q <= FastReset;
      hits_q     <= HitsReset;
      slow_lim_q <= SlowReset;
      max_win_q  <= MaxWinReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NOMINAL_HZ:   nom_q      <= cfg_data_i[NomW-1:0];
        CFG_FAST_LIMIT:   fast_lim_q <= cfg_data_i[LimW-1:0];
        CFG_HITS_TO_LOCK: hits_q     <= cfg_data_i[HitW-1:0];
        CFG_SLOW_LIMIT:   slow_lim_q <= cfg_data_i[LimW-1:0];
        CFG_MAX_WINDOW:   max_win_q  <= cfg_data_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // elapsed cycles and window close test
  assign delta     = prev_q - snap_q;
  assign close_win = (sic_q == wl_q + StartSecond);

  // deviation sign and magnitude
  assign dev_neg  = dev_q[31];
  assign dev_zero = (dev_q == '0);
  assign mag      = dev_neg ? (~dev_q + 32'd1) : dev_q;

  // saturating counters
  assign neg_inc = (neg_q == '1) ? neg_q : neg_q + 1'b1;
  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign zh_inc  = (zh_q == '1) ? zh_q : zh_q + 1'b1;
  assign need    = (hits_q == '0) ? HitW'(1) : hits_q;

  // effective window cap and window resizing
  always_comb begin
    if (max_win_q == '0) begin
      cap = WinW'(1);
    end else if (max_win_q > WinCap) begin
      cap = WinCap;
    end else begin
      cap = max_win_q;
    end
  end
  assign wl_dbl  = {wl_q, 1'b0};
  assign wl_half = (wl_q[WinW-1:1] == '0) ? WinW'(1) : {1'b0, wl_q[WinW-1:1]};

  // correction sum with saturation to 32 bits
  assign sum_w    = {{(ProdW - 31){corr_q[31]}}, corr_q} + {mul_prod[ProdW-1], mul_prod};
  assign sum_fits = (&sum_w[ProdW:31]) | ~(|sum_w[ProdW:31]);

  // sequencer
  always_comb begin
    state_d  = state_q;
    prev_d   = prev_q;
    sic_d    = sic_q;
    acc_d    = acc_q;
    wl_d     = wl_q;
    fast_d   = fast_q;
    neg_d    = neg_q;
    pos_d    = pos_q;
    zh_d     = zh_q;
    corr_d   = corr_q;
    dev_d    = dev_q;
    closed_d = closed_q;
    in_ready = 1'b0;
    load_out = 1'b0;
    mul_req  = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        prev_d = snap_q;
        acc_d  = (sic_q == StartSecond) ? '0 : acc_q + delta;
        if (close_win) begin
          sic_d          = StartSecond;
          closed_d       = 1'b1;
          mul_req.start  = 1'b1;
          mul_req.mcand  = MulAW'(nom_q);
          mul_req.mplier = MulBW'(wl_q);
          state_d        = ST_TGT_WAIT;
        end else begin
          sic_d    = sic_q + 1'b1;
          closed_d = 1'b0;
          dev_d    = '0;
          state_d  = ST_OUT;
        end
      end
      ST_TGT_WAIT: begin
        if (mul_done) begin
          dev_d   = acc_q - mul_prod[31:0];
          state_d = ST_DEV;
        end
      end
      ST_DEV: begin
        state_d        = ST_OUT;
        mul_req.mcand  = dev_q;
        mul_req.mplier = dev_neg ? neg_inc : pos_inc;
        if (fast_q) begin
          // fast acquisition: ignore large deviations
          if (mag <= 32'(fast_lim_q)) begin
            if (dev_neg) begin
              neg_d = neg_inc;
              pos_d = '0;
            end else if (!dev_zero) begin
              pos_d = pos_inc;
              neg_d = '0;
            end
            if (dev_zero) begin
              zh_d = zh_inc;
              if (zh_inc >= need) begin
                fast_d = 1'b0;
                neg_d  = '0;
                pos_d  = '0;
              end
            end else begin
              zh_d          = '0;
              mul_req.start = 1'b1;
              state_d       = ST_RUN_WAIT;
            end
          end
        end else begin
          // slow tracking: small corrections and window resizing
          if (dev_neg) begin
            neg_d = neg_inc;
            pos_d = '0;
          end else if (!dev_zero) begin
            pos_d = pos_inc;
            neg_d = '0;
          end else begin
            neg_d = '0;
            pos_d = '0;
          end
          if (!dev_zero && (mag < 32'(slow_lim_q))) begin
            mul_req.start = 1'b1;
            state_d       = ST_RUN_WAIT;
          end
          if (mag > 32'd4) begin
            wl_d = wl_half;
          end else if (mag < 32'd2) begin
            wl_d = (wl_dbl > {1'b0, cap}) ? cap : wl_dbl[WinW-1:0];
          end
        end
      end
      ST_RUN_WAIT: begin
        if (mul_done) begin
          if (sum_fits) begin
            corr_d = sum_w[31:0];
          end else begin
            corr_d = sum_w[ProdW] ? SatMin : SatMax;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and loop state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      sic_q       <= '0;
      acc_q       <= '0;
      wl_q        <= WinW'(1);
      fast_q      <= 1'b1;
      neg_q       <= '0;
      pos_q       <= '0;
      zh_q        <= '0;
      corr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      sic_q   <= sic_d;
      acc_q   <= acc_d;
      wl_q    <= wl_d;
      fast_q  <= fast_d;
      neg_q   <= neg_d;
      pos_q   <= pos_d;
      zh_q    <= zh_d;
      corr_q  <= corr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      snap_q <= in_i.count_snapshot;
    end
    dev_q    <= dev_d;
    closed_q <= closed_d;
    if (load_out) begin
      res_done_q <= closed_q;
      res_dev_q  <= dev_q;
      res_corr_q <= corr_q;
      res_fast_q <= fast_q;
      res_wl_q   <= wl_q;
      res_lock_q <= !fast_q && (wl_q >= LockWin);
    end
  end

  // channel wiring
  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.window_done      = res_done_q;
  assign out_o.deviation        = res_dev_q;
  assign out_o.correction_total = res_corr_q;
  assign out_o.fast_mode        = res_fast_q;
  assign out_o.window_seconds   = res_wl_q;
  assign out_o.locked           = res_lock_q;

`ifndef SYNTHESIS
  // a lock report never comes with fast mode
  a_lock_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_lock_q && res_fast_q))
    else $error("locked reported while in fast mode");

  // multiplier results arrive only while the sequencer waits for them
  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_TGT_WAIT || state_q == ST_RUN_WAIT))
    else $error("multiplier finished outside a wait state");

  // the second counter never runs past the close of the window
  a_sic_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wl_q != '0) && (sic_q <= wl_q + StartSecond))
    else $error("second counter passed the window close");
`endif

endmodule
